// ===== src/cau_pkg.sv =====
// Shared widths, operation codes, stage payload types and saturation helper
// for the complex arithmetic unit. No dependencies.
`default_nettype none
package cau_pkg;

  localparam int W  = 16;        // operand and result width
  localparam int FB = 8;         // fractional bits
  localparam int PW = 2 * W;     // product width
  localparam int SW = PW + 1;    // sum of two products
  localparam int QB = W + 1;     // quotient bits produced by the divider
  localparam int RW = PW + FB;   // divider partial remainder
  localparam int CW = PW + QB;   // divider compare width
  localparam int TW = PW + 1;    // square root trial width

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5
  } op_e;

  // Results that are final early ride along the pipeline.
  typedef struct packed {
    op_e          op;
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         ovf;
  } side_t;

  typedef struct packed {
    logic signed [SW-1:0] num_re;
    logic signed [SW-1:0] num_im;
    logic [PW-1:0]        den;
  } sum_t;

  typedef struct packed {
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic          dz;
    logic [PW-1:0] den;
    logic [TW-1:0] srem;
    logic [W-1:0]  root;
  } iter_t;

  // Returns {overflow, value} for a signed value clamped to W bits.
  function automatic logic [W:0] sat(input logic signed [SW-1:0] v);
    logic [W:0] r;
    r = {1'b0, v[W-1:0]};
    if (v > SW'(SMAX)) begin
      r = {1'b1, SMAX};
    end else if (v < SW'(SMIN)) begin
      r = {1'b1, SMIN};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/complex_arithmetic_unit_core.sv =====
// Top level of the complex arithmetic unit: handshake and the three pipeline
// sections. Depends on cau_pkg, cau_front, cau_iter and cau_back.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_stall_o | operation_i, a_re_i, a_im_i, b_re_i, b_im_i
//   out     | output    | out_valid_o, out_stall_i | res_re_o, res_im_o, overflow_o, div_zero_o
//
// One item per cycle while the output is not stalled; every operation passes
// the same stages from acceptance to the output register (2 product/sum
// stages, divider setup, 17 divider and square root bit stages, output stage).
// The bit-per-stage divider sets the depth. Reset clears only the valid bits.
// A held output item freezes the whole pipeline and stalls the input in the same cycle.
`default_nettype none
module complex_arithmetic_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic signed [cau_pkg::W-1:0]  a_re_i,
  input  logic signed [cau_pkg::W-1:0]  a_im_i,
  input  logic signed [cau_pkg::W-1:0]  b_re_i,
  input  logic signed [cau_pkg::W-1:0]  b_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [cau_pkg::W-1:0]  res_re_o,
  output logic signed [cau_pkg::W-1:0]  res_im_o,
  output logic                          overflow_o,
  output logic                          div_zero_o
);
  import cau_pkg::*;

  logic  en, f_valid, i_valid;
  side_t f_side, i_side;
  sum_t  f_sum;
  iter_t i_it;

  // Advance everything unless the finished item is held.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .op_i    (op_e'(operation_i)),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .sum_o   (f_sum)
  );

  cau_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .sum_i   (f_sum),
    .valid_o (i_valid),
    .side_o  (i_side),
    .it_o    (i_it)
  );

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (i_valid),
    .side_i     (i_side),
    .it_i       (i_it),
    .valid_o    (out_valid_o),
    .res_re_o   (res_re_o),
    .res_im_o   (res_im_o),
    .overflow_o (overflow_o),
    .div_zero_o (div_zero_o)
  );

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 && !overflow_o)
    else $error("divide by zero result not cleared");

  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> res_re_o == SMAX || res_re_o == SMIN ||
                                  res_im_o == SMAX || res_im_o == SMIN)
    else $error("overflow without a clamped part");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no item held");

endmodule
`default_nettype wire

// ===== src/cau_front.sv =====
// Front end: products and final add/sub/conj results in the first stage, sums
// and final mul results in the second. Depends on cau_pkg.
`default_nettype none
module cau_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  cau_pkg::op_e                   op_i,
  input  logic signed [cau_pkg::W-1:0]   a_re_i,
  input  logic signed [cau_pkg::W-1:0]   a_im_i,
  input  logic signed [cau_pkg::W-1:0]   b_re_i,
  input  logic signed [cau_pkg::W-1:0]   b_im_i,
  output logic                           valid_o,
  output cau_pkg::side_t                 side_o,
  output cau_pkg::sum_t                  sum_o
);
  import cau_pkg::*;

  logic                 v1_q, v2_q;
  side_t                side1_d, side1_q, side2_d, side2_q;
  logic signed [PW-1:0] p0_d, p1_d, p2_d, p3_d, d0_d, d1_d;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, d0_q, d1_q;
  sum_t                 sum_d, sum_q;
  logic signed [W-1:0]  x_sel, y_sel;
  logic signed [W:0]    add_re, add_im, sub_re, sub_im, neg_im;
  logic [W:0]           r0, r1;
  logic signed [SW-1:0] m_re, m_im;
  logic [W:0]           s_re, s_im;

  always_comb begin
    // Magnitude squares a through the b-side multipliers.
    x_sel = (op_i == OP_MAG) ? a_re_i : b_re_i;
    y_sel = (op_i == OP_MAG) ? a_im_i : b_im_i;
    p0_d  = a_re_i * x_sel;
    p1_d  = a_im_i * y_sel;
    p2_d  = a_re_i * b_im_i;
    p3_d  = a_im_i * b_re_i;
    d0_d  = b_re_i * b_re_i;
    d1_d  = b_im_i * b_im_i;
    add_re = {a_re_i[W-1], a_re_i} + {b_re_i[W-1], b_re_i};
    add_im = {a_im_i[W-1], a_im_i} + {b_im_i[W-1], b_im_i};
    sub_re = {a_re_i[W-1], a_re_i} - {b_re_i[W-1], b_re_i};
    sub_im = {a_im_i[W-1], a_im_i} - {b_im_i[W-1], b_im_i};
    neg_im = -{a_im_i[W-1], a_im_i};
    side1_d = '{op: op_i, re: '0, im: '0, ovf: 1'b0};
    r0 = '0;
    r1 = '0;
    case (op_i)
      OP_ADD: begin
        r0 = sat(SW'(add_re));
        r1 = sat(SW'(add_im));
      end
      OP_SUB: begin
        r0 = sat(SW'(sub_re));
        r1 = sat(SW'(sub_im));
      end
      OP_CONJ: begin
        r0 = {1'b0, a_re_i};
        r1 = sat(SW'(neg_im));
      end
      default: begin
        r0 = '0;
        r1 = '0;
      end
    endcase
    side1_d.re  = r0[W-1:0];
    side1_d.im  = r1[W-1:0];
    side1_d.ovf = r0[W] | r1[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
      d0_q    <= d0_d;
      d1_q    <= d1_d;
      side2_q <= side2_d;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    m_re = (SW'(p0_q) - SW'(p1_q)) >>> FB;
    m_im = (SW'(p2_q) + SW'(p3_q)) >>> FB;
    s_re = sat(m_re);
    s_im = sat(m_im);
    sum_d.num_re = SW'(p0_q) + SW'(p1_q);
    sum_d.num_im = SW'(p3_q) - SW'(p2_q);
    sum_d.den    = d0_q + d1_q;
    side2_d = side1_q;
    if (side1_q.op == OP_MUL) begin
      side2_d.re  = s_re[W-1:0];
      side2_d.im  = s_im[W-1:0];
      side2_d.ovf = s_re[W] | s_im[W];
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;
  assign sum_o   = sum_q;

endmodule
`default_nettype wire

// ===== src/cau_iter.sv =====
// Divider and square root pipeline: one setup stage, then one quotient bit
// per part per stage and one root bit in every stage but the first. Depends on cau_pkg.
`default_nettype none
module cau_iter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cau_pkg::side_t  side_i,
  input  cau_pkg::sum_t   sum_i,
  output logic            valid_o,
  output cau_pkg::side_t  side_o,
  output cau_pkg::iter_t  it_o
);
  import cau_pkg::*;

  logic          v_q    [QB+1];
  side_t         side_q [QB+1];
  iter_t         it_q   [QB+1];
  iter_t         setup_d;
  logic [SW-1:0] abs_re, abs_im;

  always_comb begin
    abs_re = sum_i.num_re[SW-1] ? SW'(-sum_i.num_re) : SW'(sum_i.num_re);
    abs_im = sum_i.num_im[SW-1] ? SW'(-sum_i.num_im) : SW'(sum_i.num_im);
    setup_d.rem_re = {abs_re[PW-1:0], {FB{1'b0}}};
    setup_d.rem_im = {abs_im[PW-1:0], {FB{1'b0}}};
    setup_d.q_re   = '0;
    setup_d.q_im   = '0;
    setup_d.neg_re = sum_i.num_re[SW-1];
    setup_d.neg_im = sum_i.num_im[SW-1];
    // Quotient at or above 2^QB saturates regardless of the remaining bits.
    setup_d.big_re = CW'({abs_re[PW-1:0], {FB{1'b0}}}) >= (CW'(sum_i.den) << QB);
    setup_d.big_im = CW'({abs_im[PW-1:0], {FB{1'b0}}}) >= (CW'(sum_i.den) << QB);
    setup_d.dz     = (sum_i.den == '0);
    setup_d.den    = sum_i.den;
    setup_d.srem   = TW'(sum_i.num_re[PW-1:0]);
    setup_d.root   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      it_q[0]   <= setup_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int I = QB - 1 - k;
    iter_t         nx;
    logic [CW-1:0] tden;
    logic [TW-1:0] trial;

    always_comb begin
      nx    = it_q[k];
      tden  = CW'(it_q[k].den) << I;
      trial = (TW'(it_q[k].root) << (I + 1)) + (TW'(1) << (2 * I));
      if (CW'(it_q[k].rem_re) >= tden) begin
        nx.rem_re  = RW'(CW'(it_q[k].rem_re) - tden);
        nx.q_re[I] = 1'b1;
      end
      if (CW'(it_q[k].rem_im) >= tden) begin
        nx.rem_im  = RW'(CW'(it_q[k].rem_im) - tden);
        nx.q_im[I] = 1'b1;
      end
      if ((I < W) && (it_q[k].srem >= trial)) begin
        nx.srem = it_q[k].srem - trial;
        nx.root = it_q[k].root | (W'(1) << I);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        it_q[k+1]   <= nx;
      end
    end
  end

  assign valid_o = v_q[QB];
  assign side_o  = side_q[QB];
  assign it_o    = it_q[QB];

endmodule
`default_nettype wire

// ===== src/cau_back.sv =====
// Output stage: picks the result per operation, saturates quotient and root,
// holds the result register. Depends on cau_pkg.
`default_nettype none
module cau_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  cau_pkg::side_t                side_i,
  input  cau_pkg::iter_t                it_i,
  output logic                          valid_o,
  output logic signed [cau_pkg::W-1:0]  res_re_o,
  output logic signed [cau_pkg::W-1:0]  res_im_o,
  output logic                          overflow_o,
  output logic                          div_zero_o
);
  import cau_pkg::*;

  localparam logic [QB-1:0] QMAX = QB'(SMAX);
  localparam logic [QB-1:0] QLIM = QB'(1) << (W - 1);

  logic         valid_q, ovf_d, ovf_q, dz_d, dz_q;
  logic [W-1:0] re_d, re_q, im_d, im_q;
  logic [W:0]   f_re, f_im;

  function automatic logic [W:0] fin(input logic neg, input logic big,
                                     input logic [QB-1:0] q);
    logic [W:0]    r;
    logic [QB-1:0] nq;
    nq = -q;
    if (!neg) begin
      r = (big || q > QMAX) ? {1'b1, SMAX} : {1'b0, q[W-1:0]};
    end else begin
      r = (big || q > QLIM) ? {1'b1, SMIN} : {1'b0, nq[W-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    f_re  = fin(it_i.neg_re, it_i.big_re, it_i.q_re);
    f_im  = fin(it_i.neg_im, it_i.big_im, it_i.q_im);
    re_d  = side_i.re;
    im_d  = side_i.im;
    ovf_d = side_i.ovf;
    dz_d  = 1'b0;
    case (side_i.op)
      OP_DIV: begin
        if (it_i.dz) begin
          re_d  = '0;
          im_d  = '0;
          ovf_d = 1'b0;
          dz_d  = 1'b1;
        end else begin
          re_d  = f_re[W-1:0];
          im_d  = f_im[W-1:0];
          ovf_d = f_re[W] | f_im[W];
        end
      end
      OP_MAG: begin
        ovf_d = it_i.root > SMAX;
        re_d  = ovf_d ? SMAX : it_i.root;
        im_d  = '0;
      end
      default: begin
        re_d = side_i.re;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= re_d;
      im_q  <= im_d;
      ovf_q <= ovf_d;
      dz_q  <= dz_d;
    end
  end

  assign valid_o    = valid_q;
  assign res_re_o   = re_q;
  assign res_im_o   = im_q;
  assign overflow_o = ovf_q;
  assign div_zero_o = dz_q;

endmodule
`default_nettype wire
